// File: rtl/core/ewma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EWMA volatility package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ewma_pkg;

   localparam logic [15:0] DECAY_RESET = 16'd61604;
   localparam logic [47:0] VAR_SEED    = 48'd439804651;
   localparam logic [47:0] VAR_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] VOL_MIN     = 32'd1073742;
   localparam logic [31:0] VOL_MAX     = 32'h8000_0000;
   localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
   localparam logic [7:0]  ANN_DAYS    = 8'd252;
   localparam logic [60:0] SQRT_BIT0   = 61'h1000_0000_0000_0000;
   localparam logic [4:0]  LOG_STEPS   = 5'd31;
   localparam logic [4:0]  SQRT_STEPS  = 5'd30;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_LOG,
      OP_SEED,
      OP_RET1,
      OP_RET2,
      OP_RSQ,
      OP_MUL1,
      OP_MUL2,
      OP_ANN,
      OP_SQRT,
      OP_COMMIT,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic price_zero;
      logic have_first;
   } status_type;

endpackage

// File: rtl/core/ewma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EWMA controller
// Sequences log, return, variance update and square root steps.
// ----------------------------------------------------------------------------
module ewma_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ewma_pkg::status_type status,
   output ewma_pkg::cmd_type    cmd
);
   import ewma_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOG, S_RET1, S_RET2, S_RSQ, S_MUL1, S_MUL2,
      S_ANN, S_SQRT, S_COMMIT, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               cnt_in   = '0;
               state_in = status.price_zero ? S_OUT : S_LOG;
            end
         end
         S_LOG: begin
            cmd.op = OP_LOG;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LOG_STEPS) begin
               state_in = status.have_first ? S_RET1 : S_ANN;
            end
         end
         S_RET1: begin
            cmd.op   = OP_RET1;
            state_in = S_RET2;
         end
         S_RET2: begin
            cmd.op   = OP_RET2;
            state_in = S_RSQ;
         end
         S_RSQ: begin
            cmd.op   = OP_RSQ;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_ANN;
         end
         S_ANN: begin
            cmd.op   = status.have_first ? OP_ANN : OP_SEED;
            cnt_in   = '0;
            state_in = status.have_first ? S_SQRT : S_ANN;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_STEPS) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/ewma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EWMA datapath
// Log2 by squaring, log return, variance update and bitwise square root.
// ----------------------------------------------------------------------------
module ewma_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         req_price,
   input  logic                csr_valid,
   input  logic [15:0]         csr_data,
   input  ewma_pkg::cmd_type    cmd,
   output ewma_pkg::status_type status,
   output logic [31:0]         rsp_volatility,
   output logic                rsp_ready_res
);
   import ewma_pkg::*;

   function automatic logic [4:0] msb_index(input logic [31:0] x);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   logic [15:0] decay_ff;
   logic        have_ff;
   logic [36:0] lq_ff;
   logic [47:0] var_ff;
   logic [31:0] vol_ff;
   logic [4:0]  e_ff;
   logic [31:0] m_ff;
   logic [31:0] frac_ff;
   logic [4:0]  dint_ff;
   logic [63:0] prod_ff;
   logic [36:0] r_ff;
   logic [47:0] r2_ff;
   logic [63:0] acc_ff;
   logic        sat_ff;
   logic [61:0] rem_ff;
   logic [62:0] res_ff;
   logic [60:0] bit_ff;
   logic [31:0] vol_out_ff;
   logic        ready_out_ff;

   logic [4:0]  e_load;
   logic [63:0] sq;
   logic [32:0] sq_t;
   logic [36:0] lp, d;
   logic [32:0] r28;
   logic [63:0] var_sum;
   logic [55:0] s_ann;
   logic [62:0] trial;
   logic [62:0] res_half;

   assign status.price_zero = (req_price == '0);
   assign status.have_first = have_ff;
   assign rsp_volatility    = vol_out_ff;
   assign rsp_ready_res     = ready_out_ff;

   assign e_load   = msb_index(req_price);
   assign sq       = 64'(m_ff) * 64'(m_ff);
   assign sq_t     = sq[63:31];
   assign lp       = {e_ff, frac_ff};
   assign d        = (lp >= lq_ff) ? (lp - lq_ff) : (lq_ff - lp);
   assign r28      = r_ff[36:4];
   assign var_sum  = acc_ff + 64'(17'(17'h10000 - 17'(decay_ff))) * 64'(r2_ff);
   assign s_ann    = 56'(ANN_DAYS) * 56'(var_ff);
   assign trial    = res_ff + 63'(bit_ff);
   assign res_half = res_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         have_ff      <= 1'b0;
         var_ff       <= '0;
         vol_ff       <= '0;
         vol_out_ff   <= '0;
         ready_out_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            decay_ff <= csr_data;
         end
         case (cmd.op)
            OP_LOAD: begin
               e_ff    <= e_load;
               m_ff    <= req_price << (5'd31 - e_load);
               frac_ff <= '0;
            end
            OP_LOG: begin
               if (sq_t[32]) begin
                  m_ff    <= sq_t[32:1];
                  frac_ff <= {frac_ff[30:0], 1'b1};
               end else begin
                  m_ff    <= sq_t[31:0];
                  frac_ff <= {frac_ff[30:0], 1'b0};
               end
            end
            OP_SEED: begin
               var_ff  <= VAR_SEED;
               have_ff <= 1'b1;
            end
            OP_RET1: begin
               dint_ff <= d[36:32];
               prod_ff <= 64'(d[31:0]) * 64'(LN2_Q32);
            end
            OP_RET2: begin
               r_ff <= 37'(dint_ff) * 37'(LN2_Q32) + 37'(prod_ff[63:32]);
            end
            OP_RSQ: begin
               if (r28[32]) begin
                  r2_ff <= VAR_MAX;
               end else begin
                  r2_ff <= 48'((64'(r28[31:0]) * 64'(r28[31:0])) >> 16);
               end
            end
            OP_MUL1: begin
               acc_ff <= 64'(decay_ff) * 64'(var_ff);
            end
            OP_MUL2: begin
               var_ff <= var_sum[63:16];
            end
            OP_ANN: begin
               sat_ff <= (s_ann[55:42] != '0);
               rem_ff <= {s_ann[41:0], 20'd0};
               res_ff <= '0;
               bit_ff <= SQRT_BIT0;
            end
            OP_SQRT: begin
               if (63'(rem_ff) >= trial) begin
                  rem_ff <= 62'(63'(rem_ff) - trial);
                  res_ff <= res_half + 63'(bit_ff);
               end else begin
                  res_ff <= res_half;
               end
               bit_ff <= bit_ff >> 2;
            end
            OP_COMMIT: begin
               lq_ff <= lp;
               if (sat_ff) begin
                  vol_ff <= VOL_MAX;
               end else if (res_ff < 63'(VOL_MIN)) begin
                  vol_ff <= VOL_MIN;
               end else begin
                  vol_ff <= res_ff[31:0];
               end
            end
            OP_OUT: begin
               vol_out_ff   <= vol_ff;
               ready_out_ff <= have_ff;
            end
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/ewma_volatility_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EWMA volatility estimator
// Annualized EWMA volatility of log returns of a mid price stream.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_price[31:0]
//  rsp     | out       | rsp_valid / rsp_stall | rsp_volatility[31:0], rsp_ready_res
//  csr     | in        | csr_valid / csr_ready | csr_data[15:0] (decay, Q0.16)
//
// A zero price goes straight to the output. Other prices take 32 log2
// squaring steps on a 32x32 multiplier and 31 square root steps on a
// 63-bit compare; the first price seeds the variance instead of updating it.
// Synchronous reset clears state and restores the default decay.
// One transaction is in work at a time; a stalled result holds in the
// output register while the next price is accepted.
// ----------------------------------------------------------------------------
module ewma_volatility_estimator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_price,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_volatility,
   output logic        rsp_ready_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import ewma_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ewma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ewma_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_price      (req_price),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_volatility (rsp_volatility),
      .rsp_ready_res  (rsp_ready_res)
   );

endmodule
